/* src/mfd_pkg.sv */
// Shared types and constants for the minifloat to binary64 decoder.
package mfd_pkg;

  localparam int unsigned PatW   = 64;
  localparam int unsigned ExpW   = 18;   // signed exponent width inside the datapath
  localparam int unsigned ExSatW = 15;   // saturated exponent field width
  localparam int unsigned PosW   = 6;

  localparam logic [1:0] CfgTotalBits = 2'd0;
  localparam logic [1:0] CfgExpBits   = 2'd1;
  localparam logic [1:0] CfgFracBits  = 2'd2;

  localparam logic [63:0] InfBits = 64'h7FF0_0000_0000_0000;

  // Normalised request handed to the encoder stage
  typedef struct packed {
    logic                   sign;
    logic                   zero;
    logic                   bad;
    logic [PatW-1:0]        mant;
    logic [PosW-1:0]        msb;
    logic signed [ExpW-1:0] expo;   // exponent of the leading one
  } norm_t;

endpackage

/* src/mfd_encode.sv */
// Rounds a normalised value to binary64 (nearest, ties to even) and packs it.
module mfd_encode import mfd_pkg::*; (
  input  norm_t       norm_i,
  output logic [63:0] bits_o
);

  logic signed [ExpW-1:0] q_raw, q, rs, q_adj, biased;
  logic [2*PatW-1:0]      ext;
  logic [PatW-1:0]        q0;
  logic [53:0]            r, r_fin;
  logic                   rnd;
  logic [63:0]            mag;

  always_comb begin
    q_raw = norm_i.expo - ExpW'(52);
    q     = (q_raw < -ExpW'(1074)) ? -ExpW'(1074) : q_raw;
    rs    = q - norm_i.expo + ExpW'({1'b0, norm_i.msb});
    ext   = '0;
    q0    = '0;
    rnd   = 1'b0;
    r     = '0;
    if (rs <= 0) begin
      r = 54'(norm_i.mant << 6'(-rs));
    end else if (rs <= ExpW'(64)) begin
      ext = {norm_i.mant, 64'b0} >> 7'(rs);
      q0  = ext[2*PatW-1:PatW];
      rnd = ext[63] && ((|ext[62:0]) || q0[0]);
      r   = 54'(q0) + 54'(rnd);
    end
    // rounding carried into a new binade
    if (r[53]) begin
      r_fin = r >> 1;
      q_adj = q + ExpW'(1);
    end else begin
      r_fin = r;
      q_adj = q;
    end
    biased = q_adj + ExpW'(1075);
    if (norm_i.zero) begin
      mag = '0;
    end else if (norm_i.expo > ExpW'(1023)) begin
      mag = InfBits;
    end else if (!r_fin[52]) begin
      mag = 64'(r_fin);
    end else if (biased >= ExpW'(2047)) begin
      mag = InfBits;
    end else begin
      mag = {1'b0, biased[10:0], r_fin[51:0]};
    end
    bits_o = {norm_i.sign | mag[63], mag[62:0]};
  end

endmodule

/* src/minifloat_to_double_decode.sv */
// Top level: custom minifloat pattern to IEEE 754 binary64 decoder.
// Takes one pattern per cycle and gives one result per pattern. Four register stages
// (input register, field decode, leading-one search, rounding and packing into the
// output register) lie between an accepted pattern and its result on the output.
// The whole pipeline advances whenever the output register is empty or being taken,
// so full rate holds while the sink keeps tready high.
// Configuration writes are always ready and take effect on patterns in flight too,
// so write them only while the pipeline is empty.
module minifloat_to_double_decode import mfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] pattern
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value_bits
  output logic        m_axis_tuser,   // [0] bad_widths
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  logic [6:0] total_q;
  logic [3:0] expw_q;
  logic [5:0] frac_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 7'd32;
      expw_q  <= 4'd8;
      frac_q  <= 6'd23;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTotalBits: total_q <= cfg_data_i;
        CfgExpBits:   expw_q  <= cfg_data_i[3:0];
        CfgFracBits:  frac_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;
  assign en            = !v4_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: input register
  logic [63:0] pat_q;
  always_ff @(posedge clk_i) begin
    if (en) pat_q <= s_axis_tdata;
  end

  // stage 2: field decode
  logic [6:0]        w;
  logic [63:0]       mask_w, mask_m, mask_f, pm, mag, fr, ex;
  logic [ExSatW-1:0] ex_sat_d, ex_sat_q;
  logic              sign_d, sign_q, norm_d, norm_q, bad_d, bad_q;
  logic [63:0]       mant_d, mant_q;
  logic [5:0]        f2_q;

  always_comb begin
    w      = (total_q > 7'd64) ? 7'd64 : total_q;
    mask_w = (w >= 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
    mask_m = (w == 7'd0) ? '0 : ((64'd1 << 6'(w - 7'd1)) - 64'd1);
    mask_f = (64'd1 << frac_q) - 64'd1;
    pm     = pat_q & mask_w;
    sign_d = (w != 7'd0) && pm[6'(w - 7'd1)];
    mag    = pm & mask_m;
    fr     = mag & mask_f;
    ex     = ((w != 7'd0) && ({1'b0, frac_q} < (w - 7'd1))) ? (mag >> frac_q) : '0;
    norm_d = (ex != '0);
    ex_sat_d = (ex >= 64'(2**ExSatW - 1)) ? '1 : ex[ExSatW-1:0];
    mant_d = norm_d ? ((64'd1 << frac_q) | fr) : fr;
    bad_d  = ({1'b0, total_q} != (8'd1 + 8'(expw_q) + 8'(frac_q)));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sign_q   <= sign_d;
      norm_q   <= norm_d;
      bad_q    <= bad_d;
      mant_q   <= mant_d;
      ex_sat_q <= ex_sat_d;
      f2_q     <= frac_q;
    end
  end

  // stage 3: leading-one search and exponent
  logic [PosW-1:0]        msb;
  logic signed [ExpW-1:0] bias;
  norm_t                  norm_d2, norm_q2;

  always_comb begin
    msb = '0;
    for (int i = 0; i < PatW; i++) begin
      if (mant_q[i]) msb = PosW'(i);
    end
    bias = (expw_q == 4'd0) ? '0 : ((ExpW'(1) <<< 4'(expw_q - 4'd1)) - ExpW'(1));
    norm_d2.sign = sign_q;
    norm_d2.zero = (mant_q == '0);
    norm_d2.bad  = bad_q;
    norm_d2.mant = mant_q;
    norm_d2.msb  = msb;
    norm_d2.expo = norm_q ? (ExpW'({1'b0, ex_sat_q}) - bias)
                          : (ExpW'({1'b0, msb}) + ExpW'(1) - bias - ExpW'({1'b0, f2_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en) norm_q2 <= norm_d2;
  end

  // stage 4: round, pack, output register
  logic [63:0] bits;
  mfd_encode u_enc (
    .norm_i (norm_q2),
    .bits_o (bits)
  );

  logic [63:0] out_q;
  logic        bad_out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q     <= bits;
      bad_out_q <= norm_q2.bad;
    end
  end

  assign m_axis_tdata = out_q;
  assign m_axis_tuser = bad_out_q;

endmodule

/* test/mfd_checker.sv */
// Checker for the minifloat decoder: predicts binary64 results and compares them.
module mfd_checker import mfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [63:0] value_bits;
    logic        bad_widths;
  } decoded_t;

  logic [6:0] total_q;
  logic [3:0] exp_q;
  logic [5:0] frac_q;
  decoded_t   want_q[$];

  function automatic logic [63:0] lsb_mask(int n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Round m right by sh, nearest with ties to even.
  function automatic logic [63:0] round_shift(logic [63:0] m, longint sh);
    logic [63:0] q, rem, half;
    if (sh == 0) return m;
    if (sh > 64) return '0;
    if (sh == 64) return (m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    q = m >> sh;
    rem = m & lsb_mask(int'(sh));
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  // Pack m * 2^e as binary64.
  function automatic logic [63:0] to_double(logic [63:0] m, longint e);
    int p;
    longint q, d, biased;
    logic [63:0] r;
    if (m == 0) return '0;
    p = 63;
    while (!m[p]) p--;
    if (p + e > 1023) return InfBits;
    q = p + e - 52;
    if (q < -1074) q = -1074;
    d = e - q;
    if (d >= 0) r = m << d;
    else r = round_shift(m, -d);
    if (r >= (64'd1 << 53)) begin
      r >>= 1;
      q++;
    end
    if (r < (64'd1 << 52)) return r;
    biased = q + 1075;
    if (biased >= 2047) return InfBits;
    return {biased[11:0], 52'd0} | (r & 64'h000F_FFFF_FFFF_FFFF);
  endfunction

  function automatic decoded_t decode_pattern(logic [63:0] pat);
    decoded_t res;
    int w, f;
    logic [63:0] mag, fr, ex, mant;
    longint bias, e;
    w = (total_q > 64) ? 64 : int'(total_q);
    f = int'(frac_q);
    res.bad_widths = (int'(total_q) != 1 + int'(exp_q) + f);
    res.value_bits = '0;
    if (w == 0) return res;
    pat &= lsb_mask(w);
    mag = pat & lsb_mask(w - 1);
    fr = mag & lsb_mask(f);
    ex = (f < w - 1) ? (mag >> f) : 64'd0;
    bias = (exp_q == 0) ? 0 : (longint'(1) << (exp_q - 1)) - 1;
    if (ex == 0) begin
      mant = fr;
      e = 1 - bias - f;
    end else begin
      mant = (64'd1 << f) | fr;
      e = longint'(ex) - bias - f;
    end
    res.value_bits = to_double(mant, e);
    res.value_bits[63] = res.value_bits[63] | pat[w-1];
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    decoded_t got, exp_r;
    if (!rst_ni) begin
      total_q <= 7'd32;
      exp_q <= 4'd8;
      frac_q <= 6'd23;
      fail_count_o <= 0;
      want_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgTotalBits: total_q <= cfg_data_i;
          CfgExpBits:   exp_q <= cfg_data_i[3:0];
          CfgFracBits:  frac_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) want_q.push_back(decode_pattern(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.value_bits = m_axis_tdata;
        got.bad_widths = m_axis_tuser;
        if (want_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = want_q.pop_front();
          if (got !== exp_r) begin
            if (fail_count_o < 10)
              $display("mismatch: value exp %h got %h, bad exp %b got %b",
                       exp_r.value_bits, got.value_bits, exp_r.bad_widths, got.bad_widths);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = want_q.size();

endmodule

/* test/tb.sv */
// Testbench top: stimulus, idling and verdict for the minifloat decoder.
module tb import mfd_pkg::*;;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [6:0]  cfg_data_i;
  int          fail_count, pending;
  int          send_idle_pct, recv_idle_pct;
  longint      cycles;

  minifloat_to_double_decode i_dut (.*);

  mfd_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_format(int tot, int ex, int fr);
    write_reg(CfgTotalBits, 7'(tot));
    write_reg(CfgExpBits, 7'(ex));
    write_reg(CfgFracBits, 7'(fr));
  endtask

  // wait for a clock edge before checking so the last accepted request is already counted
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_pattern(logic [63:0] pat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pat;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_pattern();
    logic [63:0] p;
    p = {$urandom(), $urandom()};
    case ($urandom_range(5))
      0: p = '0;
      1: p = '1;
      2: p = p & 64'h8000_0000_FFFF_FFFF;
      default: ;
    endcase
    return p;
  endfunction

  // Random format: mostly consistent, some mismatched, extremes now and then.
  task automatic random_format();
    int ex, fr, tot;
    ex = $urandom_range(1, 11);
    fr = $urandom_range(1, 52);
    tot = 1 + ex + fr;
    case ($urandom_range(7))
      0: tot = $urandom_range(127);
      1: ex = $urandom_range(15);
      2: fr = $urandom_range(63);
      default: ;
    endcase
    if (tot > 127) tot = 127;
    set_format(tot, ex, fr);
  endtask

  initial begin
    cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgTotalBits;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset format first, then extremes of the register space
    for (int i = 0; i < 6; i++)
      send_pattern(i == 0 ? 64'd0 : i == 1 ? '1 :
                   i == 2 ? 64'h8000_0000 : i == 3 ? 64'h7F80_0000 :
                   i == 4 ? 64'h0000_0001 : 64'h7FFF_FFFF);
    s_axis_tvalid <= 1'b0;
    drain();
    set_format(64, 11, 52);
    send_pattern(64'h7FFF_FFFF_FFFF_FFFF);
    send_pattern(64'h8000_0000_0000_0000);
    send_pattern(64'h0000_0000_0000_0001);
    s_axis_tvalid <= 1'b0;
    drain();
    set_format(3, 1, 1);
    for (int i = 0; i < 8; i++) send_pattern(64'(i));
    s_axis_tvalid <= 1'b0;
    drain();
    set_format(0, 0, 0);
    send_pattern('1);
    s_axis_tvalid <= 1'b0;
    drain();
    set_format(127, 15, 63);
    send_pattern('1);
    send_pattern(64'h7FFF_FFFF_FFFF_FFFF);
    s_axis_tvalid <= 1'b0;
    drain();
    // wide exponent field with large bias: overflow and the smallest binary64 normal
    set_format(64, 11, 1);
    send_pattern(64'h7FFF_FFFF_FFFF_FFFF);
    send_pattern(64'h0000_0000_0000_0002);
    s_axis_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 54 : 0;
      recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 24 : 0;
      for (int blk = 0; blk < 16; blk++) begin
        random_format();
        for (int k = 0; k < 33; k++) send_pattern(rand_pattern());
        s_axis_tvalid <= 1'b0;
        drain();
      end
    end

    drain();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
